// ===== rtl/core/column_group_splitter_defines.svh =====
// Assertion macros shared by the column group splitter RTL.
`ifndef COLUMN_GROUP_SPLITTER_DEFINES_SVH
`define COLUMN_GROUP_SPLITTER_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define CGS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that one condition implies another in the same cycle.
`define CGS_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/cgs_pkg.sv =====
package cgs_pkg;

    // Sizing
    localparam int MAX_GROUPS   = 8;
    localparam int OFFSET_BITS  = 16;
    localparam int COLUMN_BITS  = 8;
    localparam int COL_W        = COLUMN_BITS + 1;
    localparam int CURSOR_BITS  = 4;
    localparam int OUT_OFS_BITS = 16;

    // Column compare mask applied to 8-bit register values
    localparam logic [7:0] END_MASK = (COLUMN_BITS >= 8) ? 8'hFF
                                      : 8'((1 << COLUMN_BITS) - 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELIMITER    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_COLUMN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_COUNT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_ENDS   = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LEFTOVER = 2'd1,
        STATUS_TOO_FEW  = 2'd2,
        STATUS_OVERRUN  = 2'd3
    } status_t;

    // Classified byte as carried through the queue
    typedef struct packed {
        logic is_delim;
        logic last;
    } item_t;

    // Queue read side toward the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Register settings used by the back end
    typedef struct packed {
        logic [7:0]  first_column;
        logic [3:0]  group_count;
        logic [63:0] group_ends;
    } back_cfg_t;

    // One result
    typedef struct packed {
        logic                    group_valid;
        logic [2:0]              group_index;
        logic [OUT_OFS_BITS-1:0] start_offset;
        logic [OUT_OFS_BITS-1:0] group_length;
        logic                    record_end;
        status_t                 status;
    } result_t;

endpackage

// ===== rtl/core/column_group_splitter.sv =====
// Column group splitter: takes one record byte per request on the input channel and
// returns a request on the output channel whenever a delimiter closes the last column of
// the current group, and always for the record's last byte (record_end with status).
// Sustained rate is one byte per clock while the output does not stall; the back end's
// counter update is the one per-byte loop. A byte's result goes from its slot in the
// two-entry queue, once at the head, into the output register, where it can be taken.
// A stalled output holds its result; once both queue entries are filled behind it the
// input stalls. Bytes that complete no group and are not last produce no output request.
// Write configuration registers only while no record is in flight.
`include "column_group_splitter_defines.svh"

module column_group_splitter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [cgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [63:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic                                 last_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 group_valid,
    output logic [2:0]                           group_index,
    output logic [15:0]                          start_offset,
    output logic [15:0]                          group_length,
    output logic                                 record_end,
    output logic [1:0]                           status
);
    import cgs_pkg::*;

    logic [7:0]  delimiter_reg;
    logic [7:0]  first_column_reg;
    logic [3:0]  group_count_reg;
    logic [63:0] group_ends_reg;

    logic        push, queue_full, pop;
    item_t       push_item;
    queue_head_t head;
    back_cfg_t   back_cfg;
    result_t     result;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg    <= 8'd44;
            first_column_reg <= '0;
            group_count_reg  <= 4'd1;
            group_ends_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELIMITER:    delimiter_reg    <= cfg_data[7:0];
                REG_FIRST_COLUMN: first_column_reg <= cfg_data[7:0];
                REG_GROUP_COUNT:  group_count_reg  <= cfg_data[3:0];
                REG_GROUP_ENDS:   group_ends_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign back_cfg.first_column = first_column_reg;
    assign back_cfg.group_count  = group_count_reg;
    assign back_cfg.group_ends   = group_ends_reg;

    cgs_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .delimiter  (delimiter_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    cgs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    cgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Drive result fields
    assign group_valid  = result.group_valid;
    assign group_index  = result.group_index;
    assign start_offset = result.start_offset;
    assign group_length = result.group_length;
    assign record_end   = result.record_end;
    assign status       = result.status;

    // Every output request reports a group, a record end, or both
    `CGS_ASSERT_IMPLIES(a_out_has_reason, out_valid, group_valid || record_end,
        "output request with neither group nor record end")
    // A completed group always counts at least its delimiter
    `CGS_ASSERT_IMPLIES(a_group_len_nonzero, out_valid && group_valid, group_length != 16'd0,
        "group reported with zero length")
    // A status is only given at record end
    `CGS_ASSERT_IMPLIES(a_status_at_end, out_valid && !record_end, status == STATUS_OK,
        "status reported before record end")

endmodule

// ===== rtl/core/cgs_front.sv =====
module cgs_front (
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic [7:0]    delimiter,
    input  logic          queue_full,
    output logic          push,
    output cgs_pkg::item_t push_item
);
    import cgs_pkg::*;

    // Hold off requests while the queue has no room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Classify the byte
    always_comb
    begin
        push_item.is_delim = (data_byte == delimiter);
        push_item.last     = last_byte;
    end

endmodule

// ===== rtl/core/cgs_queue.sv =====
module cgs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cgs_pkg::item_t       push_item,
    output logic                 full,
    input  logic                 pop,
    output cgs_pkg::queue_head_t head
);
    import cgs_pkg::*;

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/cgs_back.sv =====
module cgs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cgs_pkg::back_cfg_t   cfg,
    input  cgs_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cgs_pkg::result_t     result
);
    import cgs_pkg::*;

    localparam logic [OFFSET_BITS-1:0] RUN_MAX = '1;
    localparam logic [COL_W-1:0]       COL_MAX = '1;

    logic                   in_record_reg, in_record_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [OFFSET_BITS-1:0] run_len_reg, run_len_next;
    logic [COL_W-1:0]       column_reg, column_next;
    logic [CURSOR_BITS-1:0] cursor_reg, cursor_next;
    logic                   overrun_reg, overrun_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;

    logic [OFFSET_BITS-1:0] pos, run, run_inc;
    logic [COL_W-1:0]       col, end_col;
    logic [CURSOR_BITS-1:0] cur, count;
    logic                   ovr, in_range, hit, emit;
    logic [7:0]             end_byte;

    // Take the next request when the output slot is free or being drained
    assign pop       = head.valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Clamp the group count to 1..MAX_GROUPS
    always_comb
    begin
        if (cfg.group_count == '0)
        begin
            count = CURSOR_BITS'(1);
        end
        else if (cfg.group_count > CURSOR_BITS'(MAX_GROUPS))
        begin
            count = CURSOR_BITS'(MAX_GROUPS);
        end
        else
        begin
            count = cfg.group_count;
        end
    end

    // Step the record state for one byte
    always_comb
    begin
        pos = in_record_reg ? byte_pos_reg : '0;
        run = in_record_reg ? run_len_reg : '0;
        col = in_record_reg ? column_reg : COL_W'(cfg.first_column & END_MASK);
        cur = in_record_reg ? cursor_reg : '0;
        ovr = in_record_reg ? overrun_reg : 1'b0;

        run_inc  = (run == RUN_MAX) ? run : run + 1'b1;
        end_byte = cfg.group_ends[{cur[2:0], 3'b000} +: 8];
        end_col  = COL_W'(end_byte & END_MASK);
        in_range = (cur < count);
        hit      = head.item.is_delim && in_range && (col == end_col);
        emit     = hit || head.item.last;

        byte_pos_next  = pos + 1'b1;
        run_len_next   = hit ? '0 : run_inc;
        column_next    = (head.item.is_delim && (col != COL_MAX)) ? col + 1'b1 : col;
        cursor_next    = hit ? cur + 1'b1 : cur;
        overrun_next   = ovr || (head.item.is_delim && !in_range);
        in_record_next = !head.item.last;

        result_next.group_valid  = hit;
        result_next.group_index  = hit ? cur[2:0] : '0;
        result_next.start_offset = hit ? OUT_OFS_BITS'(pos + 1'b1 - run_inc) : '0;
        result_next.group_length = hit ? OUT_OFS_BITS'(run_inc) : '0;
        result_next.record_end   = head.item.last;
        result_next.status       = STATUS_OK;
        if (head.item.last)
        begin
            if (overrun_next)
            begin
                result_next.status = STATUS_OVERRUN;
            end
            else if (run_len_next != '0)
            begin
                result_next.status = STATUS_LEFTOVER;
            end
            else if (cursor_next < count)
            begin
                result_next.status = STATUS_TOO_FEW;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_record_reg <= 1'b0;
            byte_pos_reg  <= '0;
            run_len_reg   <= '0;
            column_reg    <= '0;
            cursor_reg    <= '0;
            overrun_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                in_record_reg <= in_record_next;
                byte_pos_reg  <= byte_pos_next;
                run_len_reg   <= run_len_next;
                column_reg    <= column_next;
                cursor_reg    <= cursor_next;
                overrun_reg   <= overrun_next;
            end
        end
    end

    // Load the output slot
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule
